FILE: hw/rtl/whb_pkg.sv
// Shared types, constants and lane networks for the word-array hash block.
// No dependencies; every other file of the block imports this package.
package whb_pkg;

	// Width of the message word count
	localparam int COUNT_BITS = 16;

	// Start value of the three lanes before count and seed are added
	localparam logic [31:0] INIT_CONST = 32'hdeadbeef;

	// Front-to-back queue geometry
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

	// Lane that takes the next word of a group
	typedef enum logic [1:0] {
		SLOT_A = 2'd0,
		SLOT_B = 2'd1,
		SLOT_C = 2'd2
	} slot_t;

	typedef struct packed {
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] c;
	} lanes_t;

	// One classified item as it travels from front to back
	typedef struct packed {
		logic [31:0] word;
		logic [31:0] init;   // lane start value, meaningful on the first item
		slot_t       slot;
		logic        first;  // first item of a message
		logic        last;   // last word of a message
		logic        zero;   // message of zero words: emit init, ignore word
	} op_t;

	function automatic slot_t next_slot(input slot_t s);
		slot_t n;
		case (s)
			SLOT_A:  n = SLOT_B;
			SLOT_B:  n = SLOT_C;
			default: n = SLOT_A;
		endcase
		return n;
	endfunction

	function automatic logic [31:0] rotl32(input logic [31:0] v, input int unsigned s);
		return (v << s) | (v >> (32 - s));
	endfunction

	// Mix network, first half
	function automatic lanes_t mix_rows_1to3(input lanes_t l);
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] c;
		lanes_t      r;
		a = l.a; b = l.b; c = l.c;
		a = a - c; a = a ^ rotl32(c, 4);  c = c + b;
		b = b - a; b = b ^ rotl32(a, 6);  a = a + c;
		c = c - b; c = c ^ rotl32(b, 8);  b = b + a;
		r.a = a; r.b = b; r.c = c;
		return r;
	endfunction

	// Mix network, second half
	function automatic lanes_t mix_rows_4to6(input lanes_t l);
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] c;
		lanes_t      r;
		a = l.a; b = l.b; c = l.c;
		a = a - c; a = a ^ rotl32(c, 16); c = c + b;
		b = b - a; b = b ^ rotl32(a, 19); a = a + c;
		c = c - b; c = c ^ rotl32(b, 4);  b = b + a;
		r.a = a; r.b = b; r.c = c;
		return r;
	endfunction

	// Final avalanche, rows one to three
	function automatic lanes_t fin_rows_1to3(input lanes_t l);
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] c;
		lanes_t      r;
		a = l.a; b = l.b; c = l.c;
		c = c ^ b; c = c - rotl32(b, 14);
		a = a ^ c; a = a - rotl32(c, 11);
		b = b ^ a; b = b - rotl32(a, 25);
		r.a = a; r.b = b; r.c = c;
		return r;
	endfunction

	// Final avalanche, rows four and five
	function automatic lanes_t fin_rows_4to5(input lanes_t l);
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] c;
		lanes_t      r;
		a = l.a; b = l.b; c = l.c;
		c = c ^ b; c = c - rotl32(b, 16);
		a = a ^ c; a = a - rotl32(c, 4);
		r.a = a; r.b = b; r.c = c;
		return r;
	endfunction

	// Final avalanche, rows six and seven
	function automatic lanes_t fin_rows_6to7(input lanes_t l);
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] c;
		lanes_t      r;
		a = l.a; b = l.b; c = l.c;
		b = b ^ a; b = b - rotl32(a, 14);
		c = c ^ b; c = c - rotl32(b, 24);
		r.a = a; r.b = b; r.c = c;
		return r;
	endfunction

endpackage

FILE: hw/rtl/word_array_hash_core.sv
// Word-array hash core: streaming three-lane hash over 32-bit message words.
// The last word passes the queue, the final avalanche pipeline and the result register.
// Throughput: one word per cycle while the queue is not full; the last word waits
// when it follows a full group closely, since the mix pipeline owns the lanes.
// Reset (arst_n low, asynchronous) empties queue and pipelines; next item opens a message.
// Depends on whb_pkg, whb_front, whb_queue and whb_back.
module word_array_hash_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [31:0]                     word,
	input  logic [whb_pkg::COUNT_BITS-1:0]  word_count,
	input  logic [31:0]                     seed,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [31:0]                     hash
);
	import whb_pkg::*;

	logic q_full;
	logic push;
	op_t  push_op;
	logic q_valid;
	op_t  q_op;
	logic pop;

	whb_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.word       (word),
		.word_count (word_count),
		.seed       (seed),
		.q_full     (q_full),
		.push       (push),
		.op         (push_op)
	);

	whb_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_op (push_op),
		.full    (q_full),
		.q_valid (q_valid),
		.q_op    (q_op),
		.pop     (pop)
	);

	whb_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_op      (q_op),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.hash      (hash)
	);

endmodule

FILE: hw/rtl/whb_front.sv
// Front end: accepts items, tracks message position and classifies each item.
// Depends on whb_pkg; feeds whb_queue.
module whb_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [31:0]                     word,
	input  logic [whb_pkg::COUNT_BITS-1:0]  word_count,
	input  logic [31:0]                     seed,
	input  logic                            q_full,
	output logic                            push,
	output whb_pkg::op_t                    op
);
	import whb_pkg::*;

	logic                  in_msg_q;
	logic [COUNT_BITS-1:0] left_q;
	slot_t                 slot_q;

	logic                  first;
	logic                  zero;
	logic                  last;
	logic [COUNT_BITS-1:0] count_cur;
	logic [COUNT_BITS-1:0] left_nxt;
	slot_t                 slot_cur;
	logic [31:0]           init;

	// Classify the incoming item against the message position
	always_comb begin
		first     = !in_msg_q;
		count_cur = first ? word_count : left_q;
		zero      = first && (word_count == '0);
		left_nxt  = count_cur - COUNT_BITS'(1);
		last      = !zero && (left_nxt == '0);
		slot_cur  = first ? SLOT_A : slot_q;
		init      = INIT_CONST + (32'(word_count) << 2) + seed;
	end

	assign in_stall = q_full;
	assign push     = in_valid && !q_full;

	always_comb begin
		op.word  = word;
		op.init  = init;
		op.slot  = slot_cur;
		op.first = first;
		op.last  = last;
		op.zero  = zero;
	end

	// Message position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_msg_q <= 1'b0;
			left_q   <= '0;
			slot_q   <= SLOT_A;
		end else if (push) begin
			if (zero || last) begin
				in_msg_q <= 1'b0;
				left_q   <= '0;
				slot_q   <= SLOT_A;
			end else begin
				in_msg_q <= 1'b1;
				left_q   <= left_nxt;
				slot_q   <= next_slot(slot_cur);
			end
		end
	end

	// Inside a message at least one word is still owed
	a_left_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		in_msg_q |-> (left_q != '0))
		else $error("front inside a message with no words left");

endmodule

FILE: hw/rtl/whb_queue.sv
// Short item queue that decouples the front end from the hash back end.
// Depends on whb_pkg for the item type and depth.
module whb_queue (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  whb_pkg::op_t push_op,
	output logic         full,
	output logic         q_valid,
	output whb_pkg::op_t q_op,
	input  logic         pop
);
	import whb_pkg::*;

	op_t                  mem_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0] wr_ptr_q;
	logic [QPTR_BITS-1:0] rd_ptr_q;
	logic [QCNT_BITS-1:0] count_q;

	assign full    = (count_q == QCNT_BITS'(QUEUE_DEPTH));
	assign q_valid = (count_q != '0);
	assign q_op    = mem_q[rd_ptr_q];

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_op;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
					: wr_ptr_q + QPTR_BITS'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
					: rd_ptr_q + QPTR_BITS'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + QCNT_BITS'(1);
				2'b01:   count_q <= count_q - QCNT_BITS'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_BITS'(QUEUE_DEPTH))
		else $error("queue fill count beyond depth");

	a_no_underrun: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> q_valid)
		else $error("queue popped while empty");

endmodule

FILE: hw/rtl/whb_back.sv
// Back end: lane state, mix pipeline, final avalanche pipeline
// and the result register. Depends on whb_pkg; fed by whb_queue.
module whb_back (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         q_valid,
	input  whb_pkg::op_t q_op,
	output logic         pop,
	output logic         out_valid,
	input  logic         out_stall,
	output logic [31:0]  hash
);
	import whb_pkg::*;

	// Lane state and pending words of the current group
	lanes_t      lanes_q;
	logic [31:0] g0_q;
	logic [31:0] g1_q;

	// Mix pipeline
	logic   mix_v_s1;
	logic   mix_v_s2;
	lanes_t mix_s1;
	lanes_t mix_s2;

	// Final pipeline
	logic   fin_v_s1;
	logic   fin_v_s2;
	logic   fin_v_s3;
	logic   raw_s1;
	logic   raw_s2;
	logic   raw_s3;
	lanes_t fin_s1;
	lanes_t fin_s2;
	lanes_t fin_s3;
	lanes_t fin_tail;

	logic        out_valid_q;
	logic [31:0] hash_q;

	lanes_t      base;
	lanes_t      grp;
	lanes_t      sum;
	logic        fin_en;
	logic        need_fin;
	logic        needs_lanes;
	logic        hazard;
	logic        mix_busy;
	logic        launch_mix;

	// Group words on top of the lanes
	always_comb begin
		base  = q_op.first ? lanes_t'{a: q_op.init, b: q_op.init, c: q_op.init} : lanes_q;
		grp.a = (q_op.slot == SLOT_A) ? q_op.word : g0_q;
		grp.b = (q_op.slot == SLOT_B) ? q_op.word : ((q_op.slot == SLOT_C) ? g1_q : '0);
		grp.c = (q_op.slot == SLOT_C) ? q_op.word : '0;
		sum.a = base.a + grp.a;
		sum.b = base.b + grp.b;
		sum.c = base.c + grp.c;
	end

	// Issue control: wait for a mix in flight before reading the lanes
	always_comb begin
		fin_en      = !out_valid_q || !out_stall;
		mix_busy    = mix_v_s1 || mix_v_s2;
		need_fin    = q_op.zero || q_op.last;
		needs_lanes = !q_op.first && (q_op.last || (q_op.slot == SLOT_C));
		hazard      = needs_lanes && mix_busy;
		pop         = q_valid && !hazard && (!need_fin || fin_en);
		launch_mix  = pop && !need_fin && (q_op.slot == SLOT_C);
	end

	// Lanes and group words
	always_ff @(posedge clk) begin
		if (mix_v_s2) begin
			lanes_q <= mix_rows_4to6(mix_s2);
		end else if (pop && q_op.first && !need_fin) begin
			lanes_q <= base;
		end
		if (pop && (q_op.slot == SLOT_A)) begin
			g0_q <= q_op.word;
		end
		if (pop && (q_op.slot == SLOT_B)) begin
			g1_q <= q_op.word;
		end
		if (launch_mix) begin
			mix_s1 <= sum;
		end
		mix_s2 <= mix_rows_1to3(mix_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mix_v_s1 <= 1'b0;
			mix_v_s2 <= 1'b0;
		end else begin
			mix_v_s1 <= launch_mix;
			mix_v_s2 <= mix_v_s1;
		end
	end

	// Last two rows of the final avalanche
	assign fin_tail = fin_rows_6to7(fin_s3);

	// Final avalanche pipeline, held as a whole while the result waits
	always_ff @(posedge clk) begin
		if (fin_en) begin
			fin_s1 <= q_op.zero ? base : sum;
			raw_s1 <= q_op.zero;
			fin_s2 <= raw_s1 ? fin_s1 : fin_rows_1to3(fin_s1);
			raw_s2 <= raw_s1;
			fin_s3 <= raw_s2 ? fin_s2 : fin_rows_4to5(fin_s2);
			raw_s3 <= raw_s2;
			hash_q <= raw_s3 ? fin_s3.c : fin_tail.c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fin_v_s1    <= 1'b0;
			fin_v_s2    <= 1'b0;
			fin_v_s3    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (fin_en) begin
			fin_v_s1    <= pop && need_fin;
			fin_v_s2    <= fin_v_s1;
			fin_v_s3    <= fin_v_s2;
			out_valid_q <= fin_v_s3;
		end
	end

	assign out_valid = out_valid_q;
	assign hash      = hash_q;

	// A group takes three words, so mixes never launch back to back
	a_mix_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		mix_v_s1 |=> !mix_v_s1)
		else $error("mix launched on consecutive cycles");

	// A message never starts while the previous one still mixes
	a_first_after_mix: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && q_op.first) |-> !mix_busy)
		else $error("new message issued during a mix");

	// A mix always runs to the lane write
	a_mix_completes: assert property (@(posedge clk) disable iff (!arst_n)
		mix_v_s1 |=> mix_v_s2)
		else $error("mix pipeline dropped a group");

endmodule
